[hw/rtl/setc_pkg.sv]
// Shared types and constants for the sprite entry to tile command decoder.
// Used by the front, queue, back and top-level modules; no dependencies.
package setc_pkg;

    // Screen geometry
    localparam int TILE_SIZE     = 16;
    localparam int SCREEN_Y_BASE = 192;
    localparam int X_WRAP_LIMIT  = 480;
    localparam int X_WRAP        = 512;

    // Decoupling queue depth between front and back
    localparam int QUEUE_DEPTH_DEF = 2;

    // Configuration port
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;
    localparam logic REG_LAYER_PRIORITY = 1'b0;

    // Decoded sprite entry handed from front to back
    typedef struct packed {
        logic [11:0]       base_code;
        logic [6:0]        palette;
        logic              flip;
        logic              wide;
        logic              tall;
        logic signed [9:0] sx;
        logic signed [8:0] sy;
    } t_sprite_desc;

endpackage

[hw/rtl/setc_front.sv]
// Front end: accepts sprite entries, filters on priority and decodes them.
// Depends on setc_pkg for the descriptor type and screen constants.
module setc_front
    import setc_pkg::*;
(
    input  logic         i_valid,
    input  logic         i_queue_full,
    input  logic [1:0]   i_layer_priority,
    input  logic [7:0]   i_attr_byte,
    input  logic [7:0]   i_tile_low,
    input  logic [7:0]   i_color_byte,
    input  logic [7:0]   i_x_low,
    input  logic [7:0]   i_prio_byte,
    input  logic [7:0]   i_y_byte,
    output logic         o_ready,
    output logic         o_push,
    output t_sprite_desc o_desc
);

    logic       match;
    logic [8:0] x9;
    logic [9:0] x_wrapped;
    logic       flip;
    logic       wide;
    logic       tall;

    // Accept whenever the queue has room; mismatched entries are dropped
    assign o_ready = !i_queue_full;
    assign match   = (i_prio_byte[7:6] == i_layer_priority);
    assign o_push  = i_valid && o_ready && match;

    assign flip = i_attr_byte[5];
    assign wide = i_attr_byte[7];
    assign tall = i_prio_byte[2];

    // Wrap x into the signed range and shift narrow flipped sprites left
    assign x9 = {i_color_byte[0], i_x_low};

    always_comb begin
        if (x9 > 9'(X_WRAP_LIMIT)) begin
            x_wrapped = {1'b0, x9} - 10'(X_WRAP);
        end else begin
            x_wrapped = {1'b0, x9};
        end
        o_desc.sx = (flip && !wide) ? $signed(x_wrapped - 10'(TILE_SIZE))
                                    : $signed(x_wrapped);
    end

    // Decode code, color and y position
    always_comb begin
        o_desc.base_code = {i_attr_byte[2:0], i_tile_low[6:0], i_prio_byte[4], i_attr_byte[4]};
        o_desc.palette   = i_color_byte[7:1];
        o_desc.flip      = flip;
        o_desc.wide      = wide;
        o_desc.tall      = tall;
        o_desc.sy        = $signed(9'(SCREEN_Y_BASE) - {1'b0, i_y_byte}
                                   + (tall ? 9'd0 : 9'(TILE_SIZE)));
    end

endmodule

[hw/rtl/setc_queue.sv]
// Short FIFO of decoded sprite descriptors between front and back.
// Depends on setc_pkg for the descriptor type.
module setc_queue
    import setc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  t_sprite_desc i_desc,
    input  logic         i_pop,
    output logic         o_full,
    output logic         o_valid,
    output t_sprite_desc o_desc
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_sprite_desc r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_desc  = r_mem[r_rd_ptr];

    // Advance pointers and occupancy
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store pushed entry
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_desc;
        end
    end

endmodule

[hw/rtl/setc_back.sv]
// Back end: expands each descriptor into one to four tile commands.
// Depends on setc_pkg for the descriptor type and tile size.
module setc_back
    import setc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  t_sprite_desc      i_q_desc,
    output logic              o_q_pop,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [12:0]       o_tile_code,
    output logic [6:0]        o_palette_sel,
    output logic              o_mirror_x,
    output logic signed [9:0] o_pos_x,
    output logic signed [8:0] o_pos_y,
    output logic              o_last_tile
);

    t_sprite_desc r_desc;
    logic         r_busy;
    logic         r_row;
    logic         r_col;
    logic         r_out_valid;

    t_sprite_desc src_desc;
    logic         src_row;
    logic         src_col;
    logic         src_valid;
    logic         step;
    logic         fire;
    logic         src_last;

    // Work from the held entry, or straight from the queue head
    assign src_desc  = r_busy ? r_desc : i_q_desc;
    assign src_row   = r_busy ? r_row : 1'b0;
    assign src_col   = r_busy ? r_col : 1'b0;
    assign src_valid = r_busy || i_q_valid;
    assign step      = !r_out_valid || i_out_ready;
    assign fire      = step && src_valid;
    assign src_last  = (src_row == src_desc.tall) && (src_col == src_desc.wide);
    assign o_q_pop   = fire && !r_busy;

    // Track position within the current sprite
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (step) begin
                r_out_valid <= src_valid;
            end
            if (fire) begin
                r_busy <= !src_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_desc <= src_desc;
            if (!src_col && src_desc.wide) begin
                r_col <= 1'b1;
                r_row <= src_row;
            end else begin
                r_col <= 1'b0;
                r_row <= 1'b1;
            end
        end
    end

    // Load output register with the next tile command
    always_ff @(posedge i_clk) begin
        if (fire) begin
            o_tile_code   <= {1'b0, src_desc.base_code} + {11'd0, src_row, src_col};
            o_palette_sel <= src_desc.palette;
            o_mirror_x    <= src_desc.flip;
            o_pos_x       <= src_desc.sx + ((src_desc.flip ^ src_col) ?
                                            10'sd16 : 10'sd0);
            o_pos_y       <= src_desc.sy + (src_row ? 9'sd16 : 9'sd0);
            o_last_tile   <= src_last;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

[hw/rtl/sprite_entry_to_tile_commands_unit.sv]
// Sprite entry to tile command decoder, top level with APB register port.
// The first command of an entry passes through the queue, then the back-end output register.
// Throughput: one tile command per cycle from the back-end output register while i_out_ready is high,
// so an entry yields 1, 2 or 4 commands; a priority-mismatched entry is dropped, never queued.
// Reset (synchronous, active low) empties the queue and sets layer_priority to 0.
// Depends on setc_pkg, setc_front, setc_queue and setc_back.
module sprite_entry_to_tile_commands_unit
    import setc_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // APB register port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    // Sprite entry input
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_attr_byte,
    input  logic [7:0]         i_tile_low,
    input  logic [7:0]         i_color_byte,
    input  logic [7:0]         i_x_low,
    input  logic [7:0]         i_prio_byte,
    input  logic [7:0]         i_y_byte,
    // Tile command output
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [12:0]        o_tile_code,
    output logic [6:0]         o_palette_sel,
    output logic               o_mirror_x,
    output logic signed [9:0]  o_pos_x,
    output logic signed [8:0]  o_pos_y,
    output logic               o_last_tile
);

    logic [1:0]   r_layer_priority;
    logic         reg_write;
    logic         push;
    logic         pop;
    logic         q_full;
    logic         q_valid;
    t_sprite_desc front_desc;
    t_sprite_desc q_desc;

    // Register write and read-back
    assign pready    = 1'b1;
    assign reg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layer_priority <= 2'd0;
        end else if (reg_write && (paddr[2] == REG_LAYER_PRIORITY)) begin
            r_layer_priority <= pwdata[1:0];
        end
    end

    assign prdata = (paddr[2] == REG_LAYER_PRIORITY) ?
                    {{(PDATA_W - 2){1'b0}}, r_layer_priority} : '0;

    setc_front u_front (
        .i_valid          (i_in_valid),
        .i_queue_full     (q_full),
        .i_layer_priority (r_layer_priority),
        .i_attr_byte      (i_attr_byte),
        .i_tile_low       (i_tile_low),
        .i_color_byte     (i_color_byte),
        .i_x_low          (i_x_low),
        .i_prio_byte      (i_prio_byte),
        .i_y_byte         (i_y_byte),
        .o_ready          (o_in_ready),
        .o_push           (push),
        .o_desc           (front_desc)
    );

    setc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (front_desc),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_desc  (q_desc)
    );

    setc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_desc      (q_desc),
        .o_q_pop       (pop),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_tile_code   (o_tile_code),
        .o_palette_sel (o_palette_sel),
        .o_mirror_x    (o_mirror_x),
        .o_pos_x       (o_pos_x),
        .o_pos_y       (o_pos_y),
        .o_last_tile   (o_last_tile)
    );

endmodule

[test/tb_sprite_entry_to_tile_commands_unit.sv]
// Testbench for sprite_entry_to_tile_commands_unit: directed and random sprite entries,
// checked command by command against a built-in decoder of the entry format.
// Depends on setc_pkg and the sprite_entry_to_tile_commands_unit RTL.
`timescale 1ns / 1ps

module tb_sprite_entry_to_tile_commands_unit;
    import setc_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_HOLDOFF  = 4;
    localparam int END_HOLDOFF    = 8;
    localparam int MAX_REPORTS    = 40;

    // Register addresses: layer_priority at index 0, one unmapped slot above it
    localparam logic [PADDR_W-1:0] ADDR_LAYER_PRIORITY = PADDR_W'(REG_LAYER_PRIORITY) << 2;
    localparam logic [PADDR_W-1:0] ADDR_UNMAPPED       = PADDR_W'(4);

    typedef struct packed {
        logic [12:0]       code;
        logic [6:0]        palette;
        logic              mirror;
        logic signed [9:0] x;
        logic signed [8:0] y;
        logic              last;
    } t_tile_cmd;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [7:0]         i_attr_byte = '0;
    logic [7:0]         i_tile_low = '0;
    logic [7:0]         i_color_byte = '0;
    logic [7:0]         i_x_low = '0;
    logic [7:0]         i_prio_byte = '0;
    logic [7:0]         i_y_byte = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [12:0]        o_tile_code;
    logic [6:0]         o_palette_sel;
    logic               o_mirror_x;
    logic signed [9:0]  o_pos_x;
    logic signed [8:0]  o_pos_y;
    logic               o_last_tile;

    // Predictor state and bookkeeping
    logic [1:0]  layer_prio_model = 2'd0;
    t_tile_cmd   pending_cmds[$];
    int          error_count = 0;
    int          entries_sent = 0;
    int          entries_dropped = 0;
    int          cmds_checked = 0;
    int          idle_cycles = 0;

    // Receiver stall pattern
    int          stall_mode = 0;
    int          mode_left = 0;
    int          pattern_cnt = 0;

    sprite_entry_to_tile_commands_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_attr_byte   (i_attr_byte),
        .i_tile_low    (i_tile_low),
        .i_color_byte  (i_color_byte),
        .i_x_low       (i_x_low),
        .i_prio_byte   (i_prio_byte),
        .i_y_byte      (i_y_byte),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_tile_code   (o_tile_code),
        .o_palette_sel (o_palette_sel),
        .o_mirror_x    (o_mirror_x),
        .o_pos_x       (o_pos_x),
        .o_pos_y       (o_pos_y),
        .o_last_tile   (o_last_tile)
    );

    always #2 i_clk = ~i_clk;

    // Decode one accepted entry into the tile commands it must produce
    function automatic void predict_tile_commands(input logic [7:0] attr, input logic [7:0] tile,
                                                  input logic [7:0] colb, input logic [7:0] xlo,
                                                  input logic [7:0] prio, input logic [7:0] ybyte);
        int        base;
        int        sx;
        int        sy;
        int        rows;
        int        cols;
        int        px;
        int        py;
        int        r;
        int        c;
        logic      flip;
        logic      wide;
        logic      tall;
        t_tile_cmd cmd;
        if (prio[7:6] != layer_prio_model) begin
            entries_dropped++;
            return;
        end
        flip = attr[5];
        wide = attr[7];
        tall = prio[2];
        base = (int'(tile[6:0]) + (int'(attr[2:0]) << 7)) * 4
               + int'(attr[4]) + 2 * int'(prio[4]);
        sx = int'(xlo) + (colb[0] ? 256 : 0);
        if (sx > X_WRAP_LIMIT) begin
            sx -= X_WRAP;
        end
        sy = SCREEN_Y_BASE - int'(ybyte);
        if (!tall) begin
            sy += TILE_SIZE;
        end
        if (flip && !wide) begin
            sx -= TILE_SIZE;
        end
        rows = tall ? 2 : 1;
        cols = wide ? 2 : 1;
        for (r = 0; r < rows; r++) begin
            for (c = 0; c < cols; c++) begin
                px = sx + TILE_SIZE * (flip ? 1 - c : c);
                py = sy + TILE_SIZE * r;
                cmd.code    = 13'(base + 2 * r + c);
                cmd.palette = colb[7:1];
                cmd.mirror  = flip;
                cmd.x       = px[9:0];
                cmd.y       = py[8:0];
                cmd.last    = (r == rows - 1) && (c == cols - 1);
                pending_cmds.push_back(cmd);
            end
        end
    endfunction

    // Compare each accepted command with the oldest expected one
    always @(posedge i_clk) begin : check_commands
        t_tile_cmd got;
        t_tile_cmd exp_cmd;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = {o_tile_code, o_palette_sel, o_mirror_x, o_pos_x, o_pos_y, o_last_tile};
            if (pending_cmds.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS) begin
                    $display("%0t: unexpected command code=%0d pal=%0d flip=%0b",
                             $time, got.code, got.palette, got.mirror,
                             " x=%0d y=%0d last=%0b", got.x, got.y, got.last);
                end
            end else begin
                exp_cmd = pending_cmds.pop_front();
                cmds_checked++;
                if (got !== exp_cmd) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS) begin
                        $display("%0t: command mismatch expected code=%0d pal=%0d flip=%0b",
                                 $time, exp_cmd.code, exp_cmd.palette, exp_cmd.mirror,
                                 " x=%0d y=%0d last=%0b", exp_cmd.x, exp_cmd.y, exp_cmd.last);
                        $display("%0t:                  actual   code=%0d pal=%0d flip=%0b",
                                 $time, got.code, got.palette, got.mirror,
                                 " x=%0d y=%0d last=%0b", got.x, got.y, got.last);
                    end
                end
            end
        end
    end

    // Stall the output side: always ready, coin toss, fixed 2-of-5 window, mostly stalled
    always @(negedge i_clk) begin
        if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            mode_left  <= $urandom_range(16, 96);
        end else begin
            mode_left <= mode_left - 1;
        end
        pattern_cnt <= (pattern_cnt == 4) ? 0 : pattern_cnt + 1;
        case (stall_mode)
            0: i_out_ready <= 1'b1;
            1: i_out_ready <= 1'($urandom_range(0, 1));
            2: i_out_ready <= (pattern_cnt < 2);
            default: i_out_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // End the run when no transaction moves for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("tb: failure");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Present one entry, hold it until accepted, then predict; starts and ends on a falling edge
    task automatic send_entry(input logic [7:0] attr, input logic [7:0] tile,
                              input logic [7:0] colb, input logic [7:0] xlo,
                              input logic [7:0] prio, input logic [7:0] ybyte);
        i_in_valid   <= 1'b1;
        i_attr_byte  <= attr;
        i_tile_low   <= tile;
        i_color_byte <= colb;
        i_x_low      <= xlo;
        i_prio_byte  <= prio;
        i_y_byte     <= ybyte;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        entries_sent++;
        predict_tile_commands(attr, tile, colb, xlo, prio, ybyte);
        @(negedge i_clk);
    endtask

    task automatic idle_input(input int cycles);
        i_in_valid <= 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    // Stop sending, let every expected command arrive, then let the block settle
    task automatic drain_commands();
        idle_input(1);
        while (pending_cmds.size() != 0) @(negedge i_clk);
        repeat (DRAIN_HOLDOFF) @(negedge i_clk);
    endtask

    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (addr[PADDR_W-1:2] == REG_LAYER_PRIORITY) begin
            layer_prio_model = data[1:0];
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    // Read layer_priority back and compare with the predicted register value
    task automatic check_layer_priority_readback();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_LAYER_PRIORITY;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== PDATA_W'(layer_prio_model)) begin
            error_count++;
            $display("%0t: layer_priority readback expected %0d actual %0d",
                     $time, layer_prio_model, prdata);
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_layer_priority(input logic [1:0] level);
        drain_commands();
        apb_write(ADDR_LAYER_PRIORITY, {30'($urandom_range(0, 32'h3fff_ffff)), level});
        check_layer_priority_readback();
    endtask

    // Random entry: mostly on the active priority, some positions bunched at the x wrap
    task automatic send_random_entry(output bit hit);
        logic [7:0] attr;
        logic [7:0] tile;
        logic [7:0] colb;
        logic [7:0] xlo;
        logic [7:0] prio;
        logic [7:0] ybyte;
        attr  = $urandom_range(0, 255);
        tile  = $urandom_range(0, 255);
        colb  = $urandom_range(0, 255);
        xlo   = $urandom_range(0, 255);
        prio  = $urandom_range(0, 255);
        ybyte = $urandom_range(0, 255);
        if ($urandom_range(0, 3) != 0) begin
            prio[7:6] = layer_prio_model;
        end
        if ($urandom_range(0, 3) == 0) begin
            colb[0] = 1'b1;
            xlo     = $urandom_range(8'hd8, 8'hff);
        end
        hit = (prio[7:6] == layer_prio_model);
        send_entry(attr, tile, colb, xlo, prio, ybyte);
    endtask

    // Field extremes, every sprite shape, wrap and flip corners, dropped priorities
    task automatic test_directed_entries();
        send_entry(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        send_entry(8'hff, 8'hff, 8'hff, 8'hff, 8'h3f, 8'hff);
        send_entry(8'h80, 8'h01, 8'h02, 8'h10, 8'h00, 8'h40);
        send_entry(8'ha0, 8'h02, 8'h04, 8'h20, 8'h00, 8'h30);
        send_entry(8'h00, 8'h03, 8'h06, 8'h30, 8'h04, 8'h50);
        send_entry(8'h20, 8'h04, 8'h08, 8'h00, 8'h04, 8'h60);
        // x just inside and just past the wrap point
        send_entry(8'h00, 8'h05, 8'h01, 8'he0, 8'h00, 8'h80);
        send_entry(8'h00, 8'h06, 8'h01, 8'he1, 8'h00, 8'h80);
        send_entry(8'h20, 8'h07, 8'h01, 8'he1, 8'h00, 8'h00);
        // largest tile code, 2x2 with both code offsets in bank 7
        send_entry(8'hb7, 8'h7f, 8'hfe, 8'h10, 8'h14, 8'hc0);
        // only the ignored bits set
        send_entry(8'h48, 8'h80, 8'h00, 8'h00, 8'h2b, 8'h00);
        // three priority mismatches against the reset level, then one matching entry
        send_entry(8'h80, 8'h10, 8'h22, 8'h33, 8'h44, 8'h55);
        send_entry(8'h00, 8'h11, 8'h23, 8'h34, 8'h84, 8'h56);
        send_entry(8'ha7, 8'h12, 8'h24, 8'h35, 8'hd4, 8'h57);
        send_entry(8'h13, 8'h7f, 8'hfe, 8'hff, 8'h00, 8'h01);
        drain_commands();
    endtask

    // Every level, an unmapped address, and entries on either side of the active level
    task automatic test_register_access();
        check_layer_priority_readback();
        set_layer_priority(2'd3);
        send_entry(8'hb0, 8'h21, 8'h43, 8'h65, 8'hc4, 8'h87);
        send_entry(8'h20, 8'h22, 8'h44, 8'h66, 8'h00, 8'h88);
        drain_commands();
        apb_write(ADDR_UNMAPPED, 32'h0000_0001);
        check_layer_priority_readback();
        send_entry(8'h20, 8'h23, 8'h45, 8'h67, 8'hc0, 8'h89);
        send_entry(8'h20, 8'h24, 8'h46, 8'h68, 8'h40, 8'h8a);
        set_layer_priority(2'd1);
        send_entry(8'h85, 8'h25, 8'h47, 8'h69, 8'h44, 8'h8b);
        set_layer_priority(2'd2);
        send_entry(8'h85, 8'h26, 8'h48, 8'h6a, 8'h84, 8'h8c);
        set_layer_priority(2'd0);
        send_entry(8'h85, 8'h27, 8'h49, 8'h6b, 8'h04, 8'h8d);
    endtask

    task automatic run_random_traffic(input int target, input bit with_gaps);
        int  matched;
        bit  hit;
        matched = 0;
        while (matched < target) begin
            repeat ($urandom_range(1, 12)) begin
                send_random_entry(hit);
                if (hit) begin
                    matched++;
                end
            end
            if (with_gaps && $urandom_range(0, 2) != 0) begin
                idle_input($urandom_range(1, 8));
            end
        end
    endtask

    // One phase per priority level, draining completely between phases
    task automatic test_random_traffic();
        set_layer_priority(2'd3);
        run_random_traffic(80, 1'b1);
        set_layer_priority(2'd0);
        run_random_traffic(80, 1'b0);
        set_layer_priority(2'd1);
        run_random_traffic(80, 1'b1);
        set_layer_priority(2'd2);
        run_random_traffic(80, 1'b1);
    endtask

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed_entries();
        test_register_access();
        test_random_traffic();
        idle_input(1);
        while (pending_cmds.size() != 0) @(posedge i_clk);
        repeat (END_HOLDOFF) @(posedge i_clk);
        $display("Covered %0d sprite entries (%0d dropped on priority) over all four layer levels,",
                 entries_sent, entries_dropped);
        $display("with %0d tile commands checked and %0d errors.", cmds_checked, error_count);
        if (error_count == 0 && pending_cmds.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

[files.f]
hw/rtl/setc_pkg.sv
hw/rtl/setc_front.sv
hw/rtl/setc_queue.sv
hw/rtl/setc_back.sv
hw/rtl/sprite_entry_to_tile_commands_unit.sv
test/tb_sprite_entry_to_tile_commands_unit.sv
